@@ rtl/core/bap_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_pkg: shared types and constants of the block average pixelate core
// Register indexes, field widths, controller states and the command and
// status words between controller and datapath.
// ----------------------------------------------------------------------------
package bap_pkg;

    localparam int PIXEL_W    = 8;
    localparam int COORD_W    = 12;
    localparam int BS_W       = 5;
    localparam int DIM_W      = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;
    localparam int OUT_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

    localparam logic [BS_W-1:0]  RST_BLOCK_SIZE   = 5'd2;
    localparam logic [DIM_W-1:0] RST_IMAGE_WIDTH  = 13'd640;
    localparam logic [DIM_W-1:0] RST_IMAGE_HEIGHT = 13'd480;

    localparam logic [PIXEL_W-1:0] AVG_MAX = 8'hFF;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_OUT
    } bap_state_t;

    typedef enum logic [2:0] {
        DOP_WIDTH,
        DOP_HEIGHT,
        DOP_COLUMN,
        DOP_ROW,
        DOP_AVERAGE
    } div_op_t;

    typedef struct packed {
        logic    accept;
        logic    update;
        logic    clear_write;
        logic    div_start;
        logic    div_capture;
        div_op_t div_op;
        logic    out_load;
    } bap_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic emit;
        logic div_done;
        logic out_busy;
    } bap_status_t;

endpackage

@@ rtl/core/bap_divider.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_divider: restoring divider, one quotient bit per cycle
// Loads on start, runs W steps, pulses done with quotient and remainder held.
// ----------------------------------------------------------------------------
module bap_divider #(
    parameter int W = 19
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CNTW = $clog2(W);

    logic            busy_reg;
    logic            done_reg;
    logic [CNTW-1:0] cnt_reg;
    logic [W-1:0]    quo_reg;
    logic [W-1:0]    rem_reg;
    logic [W-1:0]    dvs_reg;

    logic [W:0] trial;
    logic [W:0] diff;
    logic       ge;

    always_comb
    begin
        trial = {rem_reg, quo_reg[W-1]};
        diff  = trial - {1'b0, dvs_reg};
        ge    = (trial >= {1'b0, dvs_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                if (cnt_reg == CNTW'(W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                cnt_reg <= cnt_reg + CNTW'(1);
            end
        end
    end

    // shift the dividend out at the top, the quotient in at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[W-2:0], ge};
            rem_reg <= ge ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

@@ rtl/core/bap_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_datapath: counters, block column sums, divider and output register
// Holds the configuration, the raster position, the per-block-column sum memory
// and the result word; acts on commands from the controller.
// ----------------------------------------------------------------------------
module bap_datapath #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [bap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]  cfg_data,
    input  logic [bap_pkg::PIXEL_W-1:0]     s_tdata,
    input  logic                            s_tuser,
    input  bap_pkg::bap_cmd_t               cmd,
    output bap_pkg::bap_status_t            stat,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bap_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);

    import bap_pkg::*;

    localparam int CW   = $clog2(MAX_WIDTH);
    localparam int DW   = CW + 1;
    localparam int NW   = $clog2(MAX_BLOCK + 1);
    localparam int OW   = $clog2(MAX_BLOCK);
    localparam int AW   = 2 * NW;
    localparam int SUMW = PIXEL_W + 2 * OW + 2;
    localparam int RNDW = SUMW + 1;
    localparam int DIVW = (RNDW > DW) ? RNDW : DW;

    // configuration
    logic [BS_W-1:0]  bs_reg;
    logic [DIM_W-1:0] iw_reg;
    logic [DIM_W-1:0] ih_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg <= RST_BLOCK_SIZE;
            iw_reg <= RST_IMAGE_WIDTH;
            ih_reg <= RST_IMAGE_HEIGHT;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BLOCK_SIZE:   bs_reg <= cfg_data[BS_W-1:0];
                REG_IMAGE_WIDTH:  iw_reg <= cfg_data[DIM_W-1:0];
                REG_IMAGE_HEIGHT: ih_reg <= cfg_data[DIM_W-1:0];
                default:          ;
            endcase
        end
    end

    logic [NW-1:0] n_c;
    logic [DW-1:0] w_c;
    logic [DW-1:0] h_c;
    logic [AW-1:0] area;

    // zero reads as one, oversize saturates
    always_comb
    begin
        if (bs_reg == '0)
            n_c = NW'(1);
        else if (32'(bs_reg) > MAX_BLOCK)
            n_c = NW'(MAX_BLOCK);
        else
            n_c = NW'(bs_reg);

        if (iw_reg == '0)
            w_c = DW'(1);
        else if (32'(iw_reg) > MAX_WIDTH)
            w_c = DW'(MAX_WIDTH);
        else
            w_c = DW'(iw_reg);

        if (ih_reg == '0)
            h_c = DW'(1);
        else if (32'(ih_reg) > MAX_WIDTH)
            h_c = DW'(MAX_WIDTH);
        else
            h_c = DW'(ih_reg);

        area = AW'(n_c) * AW'(n_c);
    end

    // raster position and block position
    logic [CW-1:0] col_reg;
    logic [CW-1:0] row_reg;
    logic [OW-1:0] offx_reg;
    logic [OW-1:0] offy_reg;
    logic [CW-1:0] bx_reg;
    logic [CW-1:0] by_reg;
    logic [OW-1:0] xrem_reg;
    logic [OW-1:0] yrem_reg;
    logic [DW-1:0] nbw_reg;
    logic [DW-1:0] nbh_reg;
    logic [CW-1:0] clr_addr_reg;

    logic [PIXEL_W-1:0] pix_reg;
    logic [SUMW-1:0]    rd_reg;
    logic [RNDW-1:0]    rnd_reg;
    logic [CW-1:0]      res_bx_reg;
    logic [CW-1:0]      res_by_reg;
    logic               res_last_reg;

    logic [DIVW-1:0] div_dvd;
    logic [DIVW-1:0] div_dvs;
    logic            div_done;
    logic [DIVW-1:0] div_quo;
    logic [DIVW-1:0] div_rem;

    logic            load;
    logic            in_crop;
    logic            at_end;
    logic            last_blk;
    logic [SUMW-1:0] new_sum;
    logic            col_wrap;
    logic            row_wrap;
    logic            offx_wrap;
    logic            offy_wrap;
    logic            xrem_wrap;
    logic            yrem_wrap;
    logic [CW-1:0]   rd_addr;
    logic            wr_en;
    logic [CW-1:0]   wr_addr;
    logic [SUMW-1:0] wr_data;

    always_comb
    begin
        load     = (offx_reg == '0) && (offy_reg == '0);
        new_sum  = load ? SUMW'(pix_reg) : rd_reg + SUMW'(pix_reg);
        in_crop  = (DW'(bx_reg) < nbw_reg) && (DW'(by_reg) < nbh_reg);
        at_end   = (NW'(offx_reg) == n_c - NW'(1)) && (NW'(offy_reg) == n_c - NW'(1));
        last_blk = (DW'(bx_reg) == nbw_reg - DW'(1)) && (DW'(by_reg) == nbh_reg - DW'(1));

        col_wrap  = (DW'(col_reg) + DW'(1)) >= w_c;
        row_wrap  = (DW'(row_reg) + DW'(1)) >= h_c;
        offx_wrap = ((NW + 1)'(offx_reg) + (NW + 1)'(1)) >= (NW + 1)'(n_c);
        offy_wrap = ((NW + 1)'(offy_reg) + (NW + 1)'(1)) >= (NW + 1)'(n_c);
        xrem_wrap = ((NW + 1)'(xrem_reg) + (NW + 1)'(1)) >= (NW + 1)'(n_c);
        yrem_wrap = ((NW + 1)'(yrem_reg) + (NW + 1)'(1)) >= (NW + 1)'(n_c);

        rd_addr = s_tuser ? '0 : bx_reg;
        wr_en   = cmd.clear_write || (cmd.update && in_crop);
        wr_addr = cmd.clear_write ? clr_addr_reg : bx_reg;
        wr_data = cmd.clear_write ? '0 : new_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            offx_reg <= '0;
            offy_reg <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            xrem_reg <= '0;
            yrem_reg <= '0;
            nbw_reg  <= '0;
            nbh_reg  <= '0;
        end
        else if (cmd.accept && s_tuser)
        begin
            col_reg  <= '0;
            row_reg  <= '0;
            offx_reg <= '0;
            offy_reg <= '0;
            bx_reg   <= '0;
            by_reg   <= '0;
            xrem_reg <= '0;
            yrem_reg <= '0;
        end
        else if (cmd.update)
        begin
            if (col_wrap)
            begin
                col_reg  <= '0;
                offx_reg <= '0;
                bx_reg   <= '0;
                xrem_reg <= '0;
                if (row_wrap)
                begin
                    row_reg  <= '0;
                    offy_reg <= '0;
                    by_reg   <= '0;
                    yrem_reg <= '0;
                end
                else
                begin
                    row_reg  <= row_reg + CW'(1);
                    offy_reg <= offy_wrap ? '0 : offy_reg + OW'(1);
                    if (yrem_wrap)
                    begin
                        yrem_reg <= '0;
                        by_reg   <= by_reg + CW'(1);
                    end
                    else
                    begin
                        yrem_reg <= yrem_reg + OW'(1);
                    end
                end
            end
            else
            begin
                col_reg  <= col_reg + CW'(1);
                offx_reg <= offx_wrap ? '0 : offx_reg + OW'(1);
                if (xrem_wrap)
                begin
                    xrem_reg <= '0;
                    bx_reg   <= bx_reg + CW'(1);
                end
                else
                begin
                    xrem_reg <= xrem_reg + OW'(1);
                end
            end
        end
        else if (cmd.div_capture)
        begin
            case (cmd.div_op)
                DOP_WIDTH:  nbw_reg <= div_quo[DW-1:0];
                DOP_HEIGHT: nbh_reg <= div_quo[DW-1:0];
                DOP_COLUMN:
                begin
                    bx_reg   <= div_quo[CW-1:0];
                    xrem_reg <= div_rem[OW-1:0];
                end
                DOP_ROW:
                begin
                    by_reg   <= div_quo[CW-1:0];
                    yrem_reg <= div_rem[OW-1:0];
                end
                default: ;
            endcase
        end
    end

    // sweep address for the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_addr_reg <= '0;
        else if (cmd.clear_write)
            clr_addr_reg <= clr_addr_reg + CW'(1);
    end

    // per-block-column sums
    logic [SUMW-1:0] sum_mem [MAX_WIDTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
            sum_mem[wr_addr] <= wr_data;
        if (cmd.accept)
            rd_reg <= sum_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            pix_reg <= s_tdata;
        if (cmd.update && in_crop && at_end)
        begin
            rnd_reg      <= RNDW'(new_sum) + RNDW'(area >> 1);
            res_bx_reg   <= bx_reg;
            res_by_reg   <= by_reg;
            res_last_reg <= last_blk;
        end
    end

    always_comb
    begin
        case (cmd.div_op)
            DOP_WIDTH:
            begin
                div_dvd = DIVW'(w_c);
                div_dvs = DIVW'(n_c);
            end
            DOP_HEIGHT:
            begin
                div_dvd = DIVW'(h_c);
                div_dvs = DIVW'(n_c);
            end
            DOP_COLUMN:
            begin
                div_dvd = DIVW'(col_reg);
                div_dvs = DIVW'(n_c);
            end
            DOP_ROW:
            begin
                div_dvd = DIVW'(row_reg);
                div_dvs = DIVW'(n_c);
            end
            DOP_AVERAGE:
            begin
                div_dvd = DIVW'(rnd_reg);
                div_dvs = DIVW'(area);
            end
            default:
            begin
                div_dvd = '0;
                div_dvs = DIVW'(1);
            end
        endcase
    end

    bap_divider #(
        .W (DIVW)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dvd),
        .divisor   (div_dvs),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // output word register
    logic                m_tvalid_reg;
    logic [PIXEL_W-1:0]  avg_out_reg;
    logic [COORD_W-1:0]  bx_out_reg;
    logic [COORD_W-1:0]  by_out_reg;
    logic                last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (cmd.out_load)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            avg_out_reg  <= (div_quo > DIVW'(AVG_MAX)) ? AVG_MAX : div_quo[PIXEL_W-1:0];
            bx_out_reg   <= COORD_W'(res_bx_reg);
            by_out_reg   <= COORD_W'(res_by_reg);
            last_out_reg <= res_last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {by_out_reg, bx_out_reg, avg_out_reg};
    assign m_tlast  = last_out_reg;

    always_comb
    begin
        stat.clear_last = (clr_addr_reg == CW'(MAX_WIDTH - 1));
        stat.emit       = in_crop && at_end;
        stat.div_done   = div_done;
        stat.out_busy   = m_tvalid_reg && !m_tready;
    end

endmodule

@@ rtl/core/bap_controller.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bap_controller: sequencer of the block average pixelate core
// Runs the clearing pass, the setup divisions after reset and configuration,
// the per-word update, the average division and the output load.
// ----------------------------------------------------------------------------
module bap_controller (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    output bap_pkg::bap_cmd_t     cmd,
    input  bap_pkg::bap_status_t  stat
);

    import bap_pkg::*;

    bap_state_t state_reg;
    bap_state_t state_next;
    div_op_t    op_reg;
    div_op_t    op_next;
    logic       dirty_reg;
    logic       dirty_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            op_reg    <= DOP_WIDTH;
            dirty_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            dirty_reg <= dirty_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        dirty_next = dirty_reg;
        s_tready   = 1'b0;
        cmd        = '0;
        cmd.div_op = op_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_write = 1'b1;
                if (stat.clear_last)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (dirty_reg)
                begin
                    dirty_next = 1'b0;
                    op_next    = DOP_WIDTH;
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    s_tready = 1'b1;
                    if (s_tvalid)
                    begin
                        cmd.accept = 1'b1;
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                if (stat.emit)
                begin
                    op_next    = DOP_AVERAGE;
                    state_next = ST_DIV_GO;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.div_capture = 1'b1;
                    case (op_reg)
                        DOP_WIDTH:
                        begin
                            op_next    = DOP_HEIGHT;
                            state_next = ST_DIV_GO;
                        end
                        DOP_HEIGHT:
                        begin
                            op_next    = DOP_COLUMN;
                            state_next = ST_DIV_GO;
                        end
                        DOP_COLUMN:
                        begin
                            op_next    = DOP_ROW;
                            state_next = ST_DIV_GO;
                        end
                        DOP_ROW:     state_next = ST_IDLE;
                        DOP_AVERAGE: state_next = ST_OUT;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase

        // a write re-runs the setup divisions before the next word
        if (cfg_we)
            dirty_next = 1'b1;
    end

endmodule

@@ rtl/core/block_average_pixelate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// block_average_pixelate_top: block average downsampling of a grey image
// Crops a raster-order 8-bit image to whole n by n blocks, sums each block
// in a per-block-column memory and emits the rounded mean on the block's
// bottom-right pixel.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | contents
//  --------+-----------+----------------------+-------------------------------
//  s_      | in        | s_tvalid / s_tready  | tdata: pixel; tuser: frame_start
//  m_      | out       | m_tvalid / m_tready  | tdata: average, block_column,
//          |           |                      | block_row; tlast: frame_done
//  cfg_    | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  A pixel word with no result passes the accept and sum update states, the
//  read-modify-write of the column sum memory; the next word waits for both.
//  A word that closes a block then runs the bit-serial divider that forms the
//  average, and waits in the output state until the result register is free.
//  After reset a clearing pass writes zero to all MAX_WIDTH sum entries, one a
//  cycle, then four setup divisions run; no word is accepted meanwhile. Every
//  configuration write re-runs the setup.
//  The result word waits in its own register; a stalled output only holds the
//  core once the next average is ready.
//
module block_average_pixelate_top #(
    parameter int MAX_WIDTH = 4096,
    parameter int MAX_BLOCK = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    // pixel words in
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,    // [7:0] pixel
    input  logic                            s_tuser,    // [0] frame_start
    // block averages out
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [31:0]                     m_tdata,    // [7:0] average,
                                                        // [19:8] block_column,
                                                        // [31:20] block_row
    output logic                            m_tlast,    // frame_done
    // register writes
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bap_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bap_pkg::CFG_DATA_W-1:0]  cfg_data
);

    import bap_pkg::*;

    bap_cmd_t    cmd;
    bap_status_t stat;
    logic        cfg_we;

    // registers are always writable; the controller replays setup afterwards
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    bap_controller u_controller (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    bap_datapath #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BLOCK (MAX_BLOCK)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // an accepted word gets its sum update on the next cycle (written only inside the crop)
    a_accept_then_update: assert property (
        @(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> cmd.update
    ) else $error("accepted word not followed by a sum update");

    // never load a new result over one still waiting downstream
    a_no_overwrite: assert property (
        @(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !(m_tvalid && !m_tready)
    ) else $error("result register loaded while output stalled");

    // a block that closes always starts its average division
    a_emit_starts_div: assert property (
        @(posedge clk) disable iff (!rst_n)
        (cmd.update && stat.emit) |=> (cmd.div_start && !s_tready)
    ) else $error("closed block did not start the divider");

endmodule
